/* rtl/grid_astar_route_search_core_defines.svh */
// Assertion helpers for the route search core.
`ifndef GRID_ASTAR_ROUTE_SEARCH_CORE_DEFINES_SVH
`define GRID_ASTAR_ROUTE_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define GARS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GARS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/gars_pkg.sv */
`default_nettype none
package gars_pkg;

  localparam int GRID_COLS      = 32;
  localparam int GRID_ROWS      = 32;
  localparam int EDGES_PER_CELL = 4;
  localparam int HEAP_DEPTH     = 4096;

  localparam int CELLS   = GRID_COLS * GRID_ROWS;
  localparam int CellW   = $clog2(CELLS);
  localparam int EdgeAw  = $clog2(CELLS * EDGES_PER_CELL);
  localparam int EcntW   = $clog2(EDGES_PER_CELL + 1);
  localparam int HeapAw  = $clog2(HEAP_DEPTH);
  localparam int HeapCw  = HeapAw + 1;
  localparam int XW      = $clog2(GRID_COLS);
  localparam int YW      = $clog2(GRID_ROWS);
  localparam int ManW    = ((XW > YW) ? XW : YW) + 1;
  localparam int CostW   = 21;
  localparam int KeyW    = CostW + 1;
  localparam int LenW    = CellW + 1;
  localparam int ResW    = 20;

  localparam logic [CostW-1:0] COST_INF = '1;

  localparam logic [2:0] MODE_CLEAR  = 3'd0;
  localparam logic [2:0] MODE_APPEND = 3'd1;
  localparam logic [2:0] MODE_OCC    = 3'd2;
  localparam logic [2:0] MODE_QUERY  = 3'd3;
  localparam logic [2:0] MODE_STEP   = 3'd4;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_ROUTE = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;
  localparam logic [1:0] STATUS_RANGE    = 2'd3;

  typedef struct packed {
    logic [2:0] mode;
    logic [4:0] node_x;
    logic [4:0] node_y;
    logic [4:0] other_x;
    logic [4:0] other_y;
    logic [7:0] weight;
    logic [7:0] occupancy;
    logic [9:0] step_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] path_cost;
    logic [19:0] expansions;
    logic [10:0] route_length;
    logic [4:0]  step_x;
    logic [4:0]  step_y;
  } rsp_t;

  typedef struct packed {
    logic             clear;
    logic             push;
    logic             pop;
    logic [CellW-1:0] loc;
    logic [KeyW-1:0]  key;
  } heap_cmd_t;

  typedef struct packed {
    logic             done;
    logic             overflow;
    logic             empty;
    logic [CellW-1:0] top;
  } heap_rsp_t;

  function automatic logic [CellW-1:0] cell_of(input logic [4:0] x, input logic [4:0] y);
    logic [CellW-1:0] cx;
    logic [CellW-1:0] cy;
    cx = CellW'(x % GRID_COLS);
    cy = CellW'(y % GRID_ROWS);
    return CellW'(cx * GRID_ROWS + cy);
  endfunction

  function automatic logic [ManW-1:0] manhattan(input logic [CellW-1:0] a,
                                                 input logic [CellW-1:0] b);
    logic [ManW-1:0] ax, ay, bx, by, dx, dy;
    ax = ManW'(a / GRID_ROWS);
    ay = ManW'(a % GRID_ROWS);
    bx = ManW'(b / GRID_ROWS);
    by = ManW'(b % GRID_ROWS);
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    return dx + dy;
  endfunction

endpackage
`default_nettype wire

/* rtl/gars_heap.sv */
`default_nettype none
module gars_heap (
  input  wire                clk,
  input  wire                rst,
  input  gars_pkg::heap_cmd_t cmd,
  output gars_pkg::heap_rsp_t rsp
);
  import gars_pkg::*;

  typedef struct packed {
    logic [CellW-1:0] loc;
    logic [KeyW-1:0]  key;
  } entry_t;

  typedef enum logic [3:0] {
    H_IDLE, H_UP_A, H_UP_B, H_POP0, H_POP1, H_POP2, H_DN_L, H_DN_R, H_DN_C
  } hstate_t;

  hstate_t           state;
  entry_t            mem [HEAP_DEPTH];
  entry_t            rdata;
  entry_t            ldata;
  entry_t            e;
  logic [HeapCw-1:0] count;
  logic [HeapAw-1:0] i;
  logic [CellW-1:0]  top;
  logic              done;
  logic              overflow;

  logic              mem_we;
  logic [HeapAw-1:0] mem_wa;
  entry_t            mem_wd;
  logic [HeapAw-1:0] mem_ra;
  logic [HeapAw-1:0] parent;
  logic [HeapCw-1:0] lidx;
  logic [HeapCw-1:0] ridx;
  logic              take_l;
  logic              take_r;
  logic [KeyW-1:0]   min_key;

  assign parent  = (i - 1'b1) >> 1;
  assign lidx    = {i, 1'b1};
  assign ridx    = HeapCw'({i, 1'b1} + 1'b1);
  assign take_l  = ldata.key < e.key;
  assign min_key = take_l ? ldata.key : e.key;
  assign take_r  = (ridx < count) && (rdata.key < min_key);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = i;
    mem_wd = e;
    mem_ra = '0;
    unique case (state)
      H_UP_A: begin
        if (i != '0) mem_ra = parent;
        else mem_we = 1'b1;
      end
      H_UP_B: begin
        mem_we = 1'b1;
        if (rdata.key > e.key) mem_wd = rdata;
      end
      H_POP0: mem_ra = '0;
      H_POP1: mem_ra = count[HeapAw-1:0];
      H_DN_L: begin
        if (lidx < count) mem_ra = lidx[HeapAw-1:0];
        else mem_we = 1'b1;
      end
      H_DN_R: mem_ra = ridx[HeapAw-1:0];
      H_DN_C: begin
        mem_we = 1'b1;
        if (take_r) mem_wd = rdata;
        else if (take_l) mem_wd = ldata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= H_IDLE;
      count    <= '0;
      done     <= 1'b0;
      overflow <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        H_IDLE: begin
          if (cmd.clear) count <= '0;
          if (cmd.push) begin
            if (count == HeapCw'(HEAP_DEPTH)) begin
              overflow <= 1'b1;
              done     <= 1'b1;
            end else begin
              overflow <= 1'b0;
              i        <= count[HeapAw-1:0];
              count    <= count + 1'b1;
              e        <= '{loc: cmd.loc, key: cmd.key};
              state    <= H_UP_A;
            end
          end else if (cmd.pop) begin
            overflow <= 1'b0;
            state    <= H_POP0;
          end
        end
        H_UP_A: begin
          if (i == '0) begin
            done  <= 1'b1;
            state <= H_IDLE;
          end else begin
            state <= H_UP_B;
          end
        end
        H_UP_B: begin
          if (rdata.key > e.key) begin
            i     <= parent;
            state <= H_UP_A;
          end else begin
            done  <= 1'b1;
            state <= H_IDLE;
          end
        end
        H_POP0: begin
          count <= count - 1'b1;
          state <= H_POP1;
        end
        H_POP1: begin
          top   <= rdata.loc;
          state <= H_POP2;
        end
        H_POP2: begin
          // last entry fills the root hole, then sinks
          e     <= rdata;
          i     <= '0;
          state <= H_DN_L;
        end
        H_DN_L: begin
          if (lidx < count) begin
            state <= H_DN_R;
          end else begin
            done  <= 1'b1;
            state <= H_IDLE;
          end
        end
        H_DN_R: begin
          ldata <= rdata;
          state <= H_DN_C;
        end
        H_DN_C: begin
          if (take_r) begin
            i     <= ridx[HeapAw-1:0];
            state <= H_DN_L;
          end else if (take_l) begin
            i     <= lidx[HeapAw-1:0];
            state <= H_DN_L;
          end else begin
            done  <= 1'b1;
            state <= H_IDLE;
          end
        end
        default: state <= H_IDLE;
      endcase
    end
  end

  assign rsp.done     = done;
  assign rsp.overflow = overflow;
  assign rsp.empty    = (count == '0);
  assign rsp.top      = top;

endmodule
`default_nettype wire

/* rtl/grid_astar_route_search_core.sv */
// channel  | handshake          | payload
// request  | start / busy       | req    (gars_pkg::req_t)
// result   | done (1-cycle)     | result (gars_pkg::rsp_t)
//
// Clear, occupancy: written in the accepting cycle. Append and step read pass
// through S_APP or S_STEP. Query: sweep of all 1024 cost table entries, then per
// heap pop a heap unit sift, reads per edge and a push for each improved edge;
// route trace walks the chain twice. Heap sift unit and memory ports set the pace.
// After rst, busy stays high while S_CLR clears edge counts and occupancy of all cells.
// done is a one-cycle strobe; the receiver cannot stall it.
`default_nettype none
module grid_astar_route_search_core (
  input  wire           clk,
  input  wire           rst,
  input  wire           start,
  input  gars_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output gars_pkg::rsp_t result
);
  import gars_pkg::*;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_APP, S_STEP, S_INIT, S_SEED, S_SEED_W, S_LOOP, S_POP_W,
    S_X_RD, S_X_GO, S_E_RD, S_E_T, S_E_CMP, S_E_PUSH, S_G_RD, S_G_GO,
    S_R_CNT, S_R_CNT_W, S_R_WR, S_R_WR_W
  } state_t;

  state_t state;

  // memories
  logic [CellW+7:0] edge_mem [CELLS*EDGES_PER_CELL];
  logic [EcntW-1:0] ecnt_mem [CELLS];
  logic [7:0]       occ_mem  [CELLS];
  logic [CostW-1:0] bc_mem   [CELLS];
  logic [CellW:0]   cf_mem   [CELLS];
  logic [CellW-1:0] rt_mem   [CELLS];

  logic [CellW+7:0] edge_rd;
  logic [EcntW-1:0] ecnt_rd;
  logic [7:0]       occ_rd;
  logic [CostW-1:0] bc_rd;
  logic [CellW:0]   cf_rd;
  logic [CellW-1:0] rt_rd;

  logic edge_we, ecnt_we, occ_we, bc_we, cf_we, rt_we;
  logic [EdgeAw-1:0] edge_wa, edge_ra;
  logic [CellW-1:0]  ecnt_wa, ecnt_ra, occ_wa, occ_ra, bc_wa, bc_ra, cf_wa, cf_ra;
  logic [CellW-1:0]  rt_wa, rt_ra;
  logic [CellW+7:0]  edge_wd;
  logic [EcntW-1:0]  ecnt_wd;
  logic [7:0]        occ_wd;
  logic [CostW-1:0]  bc_wd;
  logic [CellW:0]    cf_wd;
  logic [CellW-1:0]  rt_wd;

  // working registers
  logic [CellW:0]    sweep;
  logic [CellW-1:0]  node;
  logic [CellW-1:0]  goal;
  logic [CellW-1:0]  cur;
  logic [CellW-1:0]  tgt;
  logic [7:0]        weight;
  logic [9:0]        step_idx;
  logic [EcntW-1:0]  ecnt;
  logic [EcntW-1:0]  k;
  logic [CostW-1:0]  bcur;
  logic [CostW-1:0]  cost;
  logic [ResW-1:0]   expanded;
  logic [CellW:0]    c;
  logic [LenW-1:0]   n;
  logic [LenW-1:0]   ri;
  logic [LenW-1:0]   last_len;

  heap_cmd_t heap_cmd;
  heap_rsp_t heap_rsp;

  logic             accept;
  logic [CellW-1:0] node_in;
  logic [CellW-1:0] other_in;
  logic [CostW:0]   nc;
  logic             improve;

  assign busy     = (state != S_IDLE);
  assign accept   = start && (state == S_IDLE);
  assign node_in  = cell_of(req.node_x, req.node_y);
  assign other_in = cell_of(req.other_x, req.other_y);
  assign nc       = (CostW+1)'(bcur) + (CostW+1)'(weight) + (CostW+1)'(occ_rd);
  assign improve  = nc < {1'b0, bc_rd};

  gars_heap u_heap (
    .clk (clk),
    .rst (rst),
    .cmd (heap_cmd),
    .rsp (heap_rsp)
  );

  always_comb begin
    heap_cmd.clear = accept && (req.mode == MODE_QUERY);
    heap_cmd.push  = (state == S_SEED) || ((state == S_E_CMP) && improve);
    heap_cmd.pop   = (state == S_LOOP) && !heap_rsp.empty;
    heap_cmd.loc   = (state == S_SEED) ? node : tgt;
    heap_cmd.key   = (state == S_SEED) ? KeyW'(manhattan(node, goal))
                                       : KeyW'(nc) + KeyW'(manhattan(tgt, goal));
  end

  always_comb begin
    edge_we = 1'b0;
    edge_wa = EdgeAw'(node * EDGES_PER_CELL) + EdgeAw'(ecnt_rd);
    edge_wd = {goal, weight};
    edge_ra = EdgeAw'(cur * EDGES_PER_CELL) + EdgeAw'(k);
    ecnt_we = 1'b0;
    ecnt_wa = node;
    ecnt_wd = '0;
    ecnt_ra = node_in;
    occ_we  = 1'b0;
    occ_wa  = sweep[CellW-1:0];
    occ_wd  = '0;
    occ_ra  = edge_rd[CellW+7:8];
    bc_we   = 1'b0;
    bc_wa   = sweep[CellW-1:0];
    bc_wd   = (sweep[CellW-1:0] == node) ? '0 : COST_INF;
    bc_ra   = cur;
    cf_we   = 1'b0;
    cf_wa   = sweep[CellW-1:0];
    cf_wd   = {1'b1, {CellW{1'b0}}};
    cf_ra   = c[CellW-1:0];
    rt_we   = 1'b0;
    rt_wa   = CellW'(ri - 1'b1);
    rt_wd   = c[CellW-1:0];
    rt_ra   = CellW'(req.step_index);
    unique case (state)
      S_CLR: begin
        ecnt_we = 1'b1;
        ecnt_wa = sweep[CellW-1:0];
        occ_we  = 1'b1;
      end
      S_IDLE: begin
        if (accept && req.mode == MODE_CLEAR) begin
          ecnt_we = 1'b1;
          ecnt_wa = node_in;
        end
        if (accept && req.mode == MODE_OCC) begin
          occ_we = 1'b1;
          occ_wa = node_in;
          occ_wd = req.occupancy;
        end
      end
      S_APP: begin
        if (ecnt_rd < EcntW'(EDGES_PER_CELL)) begin
          edge_we = 1'b1;
          ecnt_we = 1'b1;
          ecnt_wd = ecnt_rd + 1'b1;
        end
      end
      S_INIT: begin
        bc_we = 1'b1;
        cf_we = 1'b1;
      end
      S_X_RD: ecnt_ra = cur;
      S_E_T:  bc_ra = edge_rd[CellW+7:8];
      S_E_CMP: begin
        if (improve) begin
          bc_we = 1'b1;
          bc_wa = tgt;
          bc_wd = nc[CostW-1:0];
          cf_we = 1'b1;
          cf_wa = tgt;
          cf_wd = {1'b0, cur};
        end
      end
      S_G_RD: bc_ra = goal;
      S_R_WR: rt_we = (ri != '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_wa] <= edge_wd;
    if (ecnt_we) ecnt_mem[ecnt_wa] <= ecnt_wd;
    if (occ_we)  occ_mem[occ_wa]   <= occ_wd;
    if (bc_we)   bc_mem[bc_wa]     <= bc_wd;
    if (cf_we)   cf_mem[cf_wa]     <= cf_wd;
    if (rt_we)   rt_mem[rt_wa]     <= rt_wd;
    edge_rd <= edge_mem[edge_ra];
    ecnt_rd <= ecnt_mem[ecnt_ra];
    occ_rd  <= occ_mem[occ_ra];
    bc_rd   <= bc_mem[bc_ra];
    cf_rd   <= cf_mem[cf_ra];
    rt_rd   <= rt_mem[rt_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      sweep    <= '0;
      done     <= 1'b0;
      last_len <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLR: begin
          sweep <= sweep + 1'b1;
          if (sweep == (CellW+1)'(CELLS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            node     <= node_in;
            goal     <= other_in;
            weight   <= req.weight;
            step_idx <= req.step_index;
            unique case (req.mode)
              MODE_APPEND: state <= S_APP;
              MODE_STEP:   state <= S_STEP;
              MODE_QUERY: begin
                sweep    <= '0;
                last_len <= '0;
                expanded <= '0;
                state    <= S_INIT;
              end
              default: ;
            endcase
          end
        end
        S_APP: state <= S_IDLE;
        S_STEP: begin
          done                <= 1'b1;
          result              <= '0;
          result.route_length <= last_len;
          if (LenW'(step_idx) < last_len) begin
            result.status <= STATUS_OK;
            result.step_x <= 5'(rt_rd / GRID_ROWS);
            result.step_y <= 5'(rt_rd % GRID_ROWS);
          end else begin
            result.status <= STATUS_RANGE;
          end
          state <= S_IDLE;
        end
        S_INIT: begin
          sweep <= sweep + 1'b1;
          if (sweep == (CellW+1)'(CELLS - 1)) state <= S_SEED;
        end
        S_SEED:   state <= S_SEED_W;
        S_SEED_W: if (heap_rsp.done) state <= S_LOOP;
        S_LOOP: begin
          if (heap_rsp.empty) begin
            done          <= 1'b1;
            result        <= '0;
            result.status <= STATUS_NO_ROUTE;
            state         <= S_IDLE;
          end else begin
            state <= S_POP_W;
          end
        end
        S_POP_W: begin
          if (heap_rsp.done) begin
            cur   <= heap_rsp.top;
            state <= (heap_rsp.top == goal) ? S_G_RD : S_X_RD;
          end
        end
        S_X_RD: state <= S_X_GO;
        S_X_GO: begin
          ecnt  <= ecnt_rd;
          bcur  <= bc_rd;
          k     <= '0;
          state <= S_E_RD;
        end
        S_E_RD: begin
          if (k >= ecnt) begin
            if (expanded != '1) expanded <= expanded + 1'b1;
            state <= S_LOOP;
          end else begin
            state <= S_E_T;
          end
        end
        S_E_T: begin
          tgt    <= edge_rd[CellW+7:8];
          weight <= edge_rd[7:0];
          state  <= S_E_CMP;
        end
        S_E_CMP: begin
          if (improve) begin
            state <= S_E_PUSH;
          end else begin
            k     <= k + 1'b1;
            state <= S_E_RD;
          end
        end
        S_E_PUSH: begin
          if (heap_rsp.done) begin
            if (heap_rsp.overflow) begin
              done          <= 1'b1;
              result        <= '0;
              result.status <= STATUS_OVERFLOW;
              state         <= S_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= S_E_RD;
            end
          end
        end
        S_G_RD: state <= S_G_GO;
        S_G_GO: begin
          cost  <= bc_rd;
          c     <= {1'b0, goal};
          n     <= '0;
          state <= S_R_CNT;
        end
        // first pass counts the chain, second writes it back to front
        S_R_CNT: begin
          if (c[CellW] || n == LenW'(CELLS)) begin
            c     <= {1'b0, goal};
            ri    <= n;
            state <= S_R_WR;
          end else begin
            n     <= n + 1'b1;
            state <= S_R_CNT_W;
          end
        end
        S_R_CNT_W: begin
          c     <= cf_rd;
          state <= S_R_CNT;
        end
        S_R_WR: begin
          if (ri == '0) begin
            done                <= 1'b1;
            last_len            <= n;
            result              <= '0;
            result.status       <= STATUS_OK;
            result.path_cost    <= cost[ResW-1:0];
            result.expansions   <= expanded;
            result.route_length <= n;
            state               <= S_IDLE;
          end else begin
            ri    <= ri - 1'b1;
            state <= S_R_WR_W;
          end
        end
        S_R_WR_W: begin
          c     <= cf_rd;
          state <= S_R_WR;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/gars_checker.sv */
`default_nettype none
`include "grid_astar_route_search_core_defines.svh"
module gars_checker (
  input wire            clk,
  input wire            rst,
  input wire            start,
  input gars_pkg::req_t req,
  input wire            busy,
  input wire            done,
  input gars_pkg::rsp_t result
);
  import gars_pkg::*;

  `GARS_ASSERT_IMP(a_done_after_busy, done, !busy && $past(busy), "result without busy work")
  `GARS_ASSERT_NXT(a_query_busy, start && !busy && req.mode == MODE_QUERY, busy, "query not taken")
  `GARS_ASSERT_IMP(a_found_len, done && result.status == STATUS_OK, result.route_length != '0, "empty route")
  `GARS_ASSERT_IMP(a_fail_zero, done && result.status != STATUS_OK, result.path_cost == '0 && result.expansions == '0, "failure carries cost")

endmodule

bind grid_astar_route_search_core gars_checker u_gars_checker (.*);
`default_nettype wire

/* sim/tb_grid_astar_route_search_core.sv */
`default_nettype none
module tb_grid_astar_route_search_core;
  import gars_pkg::*;

  localparam int CycleLimit = 4000000;
  localparam int NumCells   = 1024;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t rsp;
  } stim_row_t;

  logic clk;
  logic rst;
  logic start;
  req_t req;
  logic busy;
  logic done;
  rsp_t result;

  grid_astar_route_search_core dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .req(req),
    .busy(busy),
    .done(done),
    .result(result)
  );

  // shadow copy of the grid and of the last route
  int unsigned edge_tgt [NumCells*4];
  int unsigned edge_wt  [NumCells*4];
  int unsigned edge_cnt [NumCells];
  int unsigned occ      [NumCells];
  int unsigned best     [NumCells];
  int          from_cell[NumCells];
  int unsigned heap_cell[4096];
  int unsigned heap_key [4096];
  int unsigned heap_n;
  int unsigned route    [NumCells];
  int unsigned route_len;

  rsp_t      route_rsp_q[$];
  stim_row_t dir_rows[$];
  int        fails;
  int        cycles;
  int        idle_pct;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (!rst && done) begin
      if (route_rsp_q.size() == 0) begin
        fails <= fails + 1;
        if (fails < 10) $display("unexpected result %p", result);
      end else begin
        exp_rsp = route_rsp_q.pop_front();
        if (result.status !== exp_rsp.status || result.path_cost !== exp_rsp.path_cost ||
            result.expansions !== exp_rsp.expansions ||
            result.route_length !== exp_rsp.route_length ||
            result.step_x !== exp_rsp.step_x || result.step_y !== exp_rsp.step_y) begin
          fails <= fails + 1;
          if (fails < 10) $display("mismatch: exp %p got %p", exp_rsp, result);
        end
      end
    end
  end

  function automatic int unsigned cell_idx(logic [4:0] x, logic [4:0] y);
    return x * 32 + y;
  endfunction

  function automatic int unsigned manh_dist(int unsigned a, int unsigned b);
    int ax, ay, bx, by;
    ax = a / 32; ay = a % 32; bx = b / 32; by = b % 32;
    return ((ax > bx) ? ax - bx : bx - ax) + ((ay > by) ? ay - by : by - ay);
  endfunction

  function automatic bit heap_add(int unsigned c, int unsigned k);
    int unsigned i, p, tc, tk;
    if (heap_n >= 4096) return 1'b0;
    i = heap_n;
    heap_n++;
    heap_cell[i] = c;
    heap_key[i] = k;
    while (i > 0 && heap_key[(i-1)/2] > heap_key[i]) begin
      p = (i - 1) / 2;
      tc = heap_cell[i]; tk = heap_key[i];
      heap_cell[i] = heap_cell[p]; heap_key[i] = heap_key[p];
      heap_cell[p] = tc; heap_key[p] = tk;
      i = p;
    end
    return 1'b1;
  endfunction

  function automatic int unsigned heap_take();
    int unsigned top, i, l, r, m, tc, tk;
    top = heap_cell[0];
    i = 0;
    heap_n--;
    heap_cell[0] = heap_cell[heap_n];
    heap_key[0] = heap_key[heap_n];
    while (2 * i + 1 < heap_n) begin
      l = 2 * i + 1; r = 2 * i + 2; m = i;
      if (heap_key[l] < heap_key[m]) m = l;
      if (r < heap_n && heap_key[r] < heap_key[m]) m = r;
      if (m == i) break;
      tc = heap_cell[i]; tk = heap_key[i];
      heap_cell[i] = heap_cell[m]; heap_key[i] = heap_key[m];
      heap_cell[m] = tc; heap_key[m] = tk;
      i = m;
    end
    return top;
  endfunction

  function automatic rsp_t search_route(int unsigned s, int unsigned g);
    rsp_t res;
    int unsigned cur, t, nc, n, slot, expanded;
    int c;
    res = '0;
    expanded = 0;
    for (int i = 0; i < NumCells; i++) begin
      best[i] = 32'hFFFF_FFFF;
      from_cell[i] = -1;
    end
    heap_n = 0;
    route_len = 0;
    best[s] = 0;
    void'(heap_add(s, manh_dist(s, g)));
    while (heap_n > 0) begin
      cur = heap_take();
      if (cur == g) begin
        n = 0;
        c = cur;
        while (c != -1 && n < NumCells) begin
          n++;
          c = from_cell[c];
        end
        c = cur;
        for (int i = n; i > 0; i--) begin
          route[i-1] = c;
          c = from_cell[c];
        end
        route_len = n;
        res.status = STATUS_OK;
        res.path_cost = best[g][19:0];
        res.expansions = expanded[19:0];
        res.route_length = n[10:0];
        return res;
      end
      for (int i = 0; i < edge_cnt[cur]; i++) begin
        slot = cur * 4 + i;
        t = edge_tgt[slot];
        nc = best[cur] + edge_wt[slot] + occ[t];
        if (nc < best[t]) begin
          from_cell[t] = cur;
          best[t] = nc;
          if (!heap_add(t, nc + manh_dist(t, g))) begin
            res.status = STATUS_OVERFLOW;
            return res;
          end
        end
      end
      if (expanded < 20'hFFFFF) expanded++;
    end
    res.status = STATUS_NO_ROUTE;
    return res;
  endfunction

  task automatic predict_route(input req_t r, output bit has_rsp, output rsp_t res);
    int unsigned node, slot;
    node = cell_idx(r.node_x, r.node_y);
    has_rsp = 1'b0;
    res = '0;
    case (r.mode)
      MODE_CLEAR: edge_cnt[node] = 0;
      MODE_APPEND: begin
        if (edge_cnt[node] < 4) begin
          slot = node * 4 + edge_cnt[node];
          edge_tgt[slot] = cell_idx(r.other_x, r.other_y);
          edge_wt[slot] = r.weight;
          edge_cnt[node]++;
        end
      end
      MODE_OCC: occ[node] = r.occupancy;
      MODE_QUERY: begin
        has_rsp = 1'b1;
        res = search_route(node, cell_idx(r.other_x, r.other_y));
      end
      MODE_STEP: begin
        has_rsp = 1'b1;
        res.route_length = route_len[10:0];
        if (r.step_index < route_len) begin
          res.status = STATUS_OK;
          res.step_x = 5'(route[r.step_index] / 32);
          res.step_y = 5'(route[r.step_index] % 32);
        end else begin
          res.status = STATUS_RANGE;
        end
      end
      default: ;
    endcase
  endtask

  // drive one request; start stays high after acceptance until the next call
  task automatic send_req(input req_t r, input bit typed, input rsp_t typed_rsp);
    bit   has_rsp;
    rsp_t res;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    req <= r;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predict_route(r, has_rsp, res);
    if (has_rsp) route_rsp_q.push_back(typed ? typed_rsp : res);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    wait (route_rsp_q.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic req_t mk(logic [2:0] m, logic [4:0] nx, logic [4:0] ny,
                              logic [4:0] ox, logic [4:0] oy, logic [7:0] w,
                              logic [7:0] o, logic [9:0] idx);
    req_t r;
    r.mode = m; r.node_x = nx; r.node_y = ny; r.other_x = ox; r.other_y = oy;
    r.weight = w; r.occupancy = o; r.step_index = idx;
    return r;
  endfunction

  function automatic rsp_t mkr(logic [1:0] st, logic [10:0] len, logic [4:0] x,
                               logic [4:0] y);
    rsp_t p;
    p = '0;
    p.status = st; p.route_length = len; p.step_x = x; p.step_y = y;
    return p;
  endfunction

  task automatic add_row(input req_t r, input bit typed = 1'b0, input rsp_t p = '0);
    stim_row_t row;
    row.req = r; row.typed = typed; row.rsp = p;
    dir_rows.push_back(row);
  endtask

  // mostly small local graphs so routes are deep but queries stay short
  function automatic req_t rand_req();
    req_t r;
    int   pick;
    r = req_t'({$urandom, $urandom});
    pick = $urandom_range(99);
    if (pick < 38) r.mode = MODE_APPEND;
    else if (pick < 43) r.mode = MODE_CLEAR;
    else if (pick < 53) r.mode = MODE_OCC;
    else if (pick < 70) r.mode = MODE_QUERY;
    else if (pick < 95) r.mode = MODE_STEP;
    else r.mode = 3'($urandom_range(5, 7));
    if ($urandom_range(9) != 0) begin
      r.node_x = 5'($urandom_range(0, 5)); r.node_y = 5'($urandom_range(0, 5));
      r.other_x = 5'($urandom_range(0, 5)); r.other_y = 5'($urandom_range(0, 5));
      if ($urandom_range(1)) r.weight = 8'($urandom_range(0, 15));
      if ($urandom_range(1)) r.occupancy = 8'($urandom_range(0, 7));
      if ($urandom_range(3) != 0) r.step_index = 10'($urandom_range(0, 14));
    end
    return r;
  endfunction

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    fails = 0;
    cycles = 0;
    idle_pct = 0;
    for (int i = 0; i < NumCells; i++) begin
      edge_cnt[i] = 0;
      occ[i] = 0;
    end
    route_len = 0;

    add_row(mk(MODE_STEP, 0, 0, 0, 0, 0, 0, 0), 1, mkr(STATUS_RANGE, 0, 0, 0));
    add_row(mk(MODE_STEP, 0, 0, 0, 0, 0, 0, 1023), 1, mkr(STATUS_RANGE, 0, 0, 0));
    add_row(mk(MODE_QUERY, 3, 4, 3, 4, 0, 0, 0), 1, mkr(STATUS_OK, 1, 0, 0));
    add_row(mk(MODE_STEP, 0, 0, 0, 0, 0, 0, 0), 1, mkr(STATUS_OK, 1, 3, 4));
    add_row(mk(MODE_STEP, 0, 0, 0, 0, 0, 0, 1), 1, mkr(STATUS_RANGE, 1, 0, 0));
    add_row(mk(MODE_QUERY, 0, 0, 31, 31, 0, 0, 0), 1, mkr(STATUS_NO_ROUTE, 0, 0, 0));
    add_row(mk(MODE_STEP, 0, 0, 0, 0, 0, 0, 0), 1, mkr(STATUS_RANGE, 0, 0, 0));
    add_row(mk(MODE_APPEND, 0, 0, 0, 1, 255, 0, 0));
    add_row(mk(MODE_APPEND, 0, 1, 31, 31, 0, 0, 0));
    add_row(mk(MODE_OCC, 31, 31, 0, 0, 0, 255, 0));
    add_row(mk(MODE_OCC, 0, 1, 0, 0, 0, 7, 0));
    add_row(mk(MODE_QUERY, 0, 0, 31, 31, 0, 0, 0));
    add_row(mk(MODE_STEP, 0, 0, 0, 0, 0, 0, 1));
    add_row(mk(MODE_STEP, 0, 0, 0, 0, 0, 0, 2));
    add_row(mk(MODE_APPEND, 0, 0, 1, 0, 1, 0, 0));
    add_row(mk(MODE_APPEND, 0, 0, 1, 1, 2, 0, 0));
    add_row(mk(MODE_APPEND, 0, 0, 31, 31, 3, 0, 0));
    add_row(mk(MODE_APPEND, 0, 0, 2, 2, 0, 0, 0)); // edge list full, dropped
    add_row(mk(3'd5, 31, 31, 31, 31, 255, 255, 1023));
    add_row(mk(3'd7, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(MODE_QUERY, 0, 0, 31, 31, 0, 0, 0));
    add_row(mk(MODE_STEP, 0, 0, 0, 0, 0, 0, 1));
    add_row(mk(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(MODE_QUERY, 0, 0, 31, 31, 0, 0, 0));
    add_row(mk(MODE_STEP, 0, 0, 0, 0, 0, 0, 0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1: idle_pct = 78;
        3: idle_pct = 15;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < 30; n++) send_req(rand_req(), 1'b0, '0);
      drain();
    end

    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* grid_astar_route_search_core.f */
+incdir+rtl
rtl/gars_pkg.sv
rtl/gars_heap.sv
rtl/grid_astar_route_search_core.sv
rtl/gars_checker.sv
sim/tb_grid_astar_route_search_core.sv
